@@ sv/pretrigger_capture_window_core_assert.svh @@
// Assertion macros used by the pretrigger capture window checker.
`ifndef PRETRIGGER_CAPTURE_WINDOW_CORE_ASSERT_SVH
`define PRETRIGGER_CAPTURE_WINDOW_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PCW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pcw_pkg.sv @@
// Shared types and constants of the pretrigger capture window core.
package pcw_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int PREROLL_W     = 15;
   localparam int POSTROLL_W    = 24;
   localparam int CSR_DATA_W    = 24;
   localparam int CSR_INDEX_W   = 2;
   localparam int REMAIN_W      = 25;
   localparam int PREROLL_RESET = 16384;
   localparam int POSTROLL_RESET = 48000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PREROLL  = 2'd0,
      CSR_POSTROLL = 2'd1
   } csr_index_type;

endpackage

@@ sv/pcw_ring.sv @@
// History ring storage: one write port, one read port with registered data.
module pcw_ring
   import pcw_pkg::*;
#(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // write the new sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pretrigger_capture_window_core.sv @@
// Pretrigger capture window: one sample accepted per cycle, one result out per cycle,
// while the output is not stalled. A result passes through the ring read stage and then
// the output register before it appears on rsp_; throughput is one sample per cycle
// while rsp_ready holds, set by the single ring write and read port.
// Reset (synchronous): restores the default lengths, clears pointers, fill count, event
// state and output valid; ring contents are kept, the fill count marks live history.
module pretrigger_capture_window_core
   import pcw_pkg::*;
#(
   parameter int RING_DEPTH = 16384
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_trigger,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_first_mark,
   output logic                       rsp_last_mark,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int LW = $clog2(RING_DEPTH + 1);
   localparam int LEN_RESET = (PREROLL_RESET > RING_DEPTH) ? RING_DEPTH : PREROLL_RESET;

   // configuration and event state
   logic [LW-1:0]         len_ff;
   logic [POSTROLL_W-1:0] postroll_ff;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [AW-1:0]         rp_ff, rp_in;
   logic [LW-1:0]         fill_ff, fill_in;
   logic                  capturing_ff, capturing_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;

   // ring read stage
   logic                s1_valid_ff, s1_first_ff, s1_last_ff, s1_fwd_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [SAMPLE_W-1:0] ring_rd_data;

   // output register
   logic                rsp_valid_ff, rsp_first_ff, rsp_last_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff;

   logic                 req_accept, s1_advance;
   logic                 start, emit, last;
   logic [LW-1:0]        wp_inc, rd_inc, fill_m1;
   logic [LW:0]          wrap_sum;
   logic [AW-1:0]        start_rp, rd_addr;
   logic [REMAIN_W-1:0]  remain_base;
   logic [PREROLL_W-1:0] prl_raw;
   logic [LW-1:0]        prl_len;

   // handshake: the read stage drains whenever the output register frees up
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // step the event state for the offered sample
   always_comb begin
      wp_inc  = LW'(wp_ff) + LW'(1);
      wp_in   = (wp_inc >= len_ff) ? '0 : AW'(wp_inc);
      fill_in = (fill_ff < len_ff) ? fill_ff + LW'(1) : fill_ff;
      fill_m1 = fill_in - LW'(1);

      // oldest buffered sample, counted back from the entry written now
      wrap_sum = (LW+1)'(wp_ff) + (LW+1)'(len_ff) - (LW+1)'(fill_m1);
      if (LW'(wp_ff) >= fill_m1) begin
         start_rp = AW'(LW'(wp_ff) - fill_m1);
      end else begin
         start_rp = AW'(wrap_sum);
      end

      start   = !capturing_ff && req_trigger;
      emit    = capturing_ff || req_trigger;
      rd_addr = capturing_ff ? rp_ff : start_rp;
      rd_inc  = LW'(rd_addr) + LW'(1);
      rp_in   = (rd_inc >= len_ff) ? '0 : AW'(rd_inc);

      remain_base = capturing_ff ? remain_ff
                                 : REMAIN_W'(fill_in) + REMAIN_W'(postroll_ff);
      remain_in   = (remain_base != '0) ? remain_base - REMAIN_W'(1) : '0;
      last        = (remain_in == '0);
      capturing_in = !last;
   end

   // clamp a written preroll length into 1..RING_DEPTH
   always_comb begin
      prl_raw = csr_wdata[PREROLL_W-1:0];
      if (prl_raw == '0) begin
         prl_len = LW'(1);
      end else if (32'(prl_raw) > 32'(RING_DEPTH)) begin
         prl_len = LW'(RING_DEPTH);
      end else begin
         prl_len = LW'(prl_raw);
      end
   end

   // configuration registers and event state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LW'(LEN_RESET);
         postroll_ff  <= POSTROLL_W'(POSTROLL_RESET);
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         capturing_ff <= 1'b0;
         remain_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PREROLL: begin
               len_ff       <= prl_len;
               wp_ff        <= '0;
               rp_ff        <= '0;
               fill_ff      <= '0;
               capturing_ff <= 1'b0;
               remain_ff    <= '0;
            end
            CSR_POSTROLL: begin
               postroll_ff <= csr_wdata[POSTROLL_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (req_accept) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         if (emit) begin
            rp_ff        <= rp_in;
            remain_ff    <= remain_in;
            capturing_ff <= capturing_in;
         end
      end
   end

   pcw_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wp_ff),
      .wr_data (req_sample_in),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (ring_rd_data)
   );

   // read stage: flags, plus a bypass when the window reads the entry written now
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= emit;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_first_ff  <= start;
         s1_last_ff   <= last;
         s1_fwd_ff    <= (rd_addr == wp_ff);
         s1_sample_ff <= req_sample_in;
      end
   end

   // output register: advance when empty or when the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_sample_ff <= s1_fwd_ff ? s1_sample_ff : ring_rd_data;
         rsp_first_ff  <= s1_first_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_first_mark = rsp_first_ff;
   assign rsp_last_mark  = rsp_last_ff;

endmodule

@@ sv/pcw_checker.sv @@
// Port-level checker for the pretrigger capture window core, bound to the core module.
`include "pretrigger_capture_window_core_assert.svh"

module pcw_checker
   import pcw_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_first_mark,
   input logic                       rsp_last_mark,
   input logic                       csr_wr_en,
   input logic [CSR_INDEX_W-1:0]     csr_index
);

   logic window_open_ff, window_open_in;

   // track whether a window has started and not yet closed
   always_comb begin
      window_open_in = window_open_ff;
      if (csr_wr_en && csr_index == CSR_PREROLL) begin
         window_open_in = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         window_open_in = !rsp_last_mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
      end else begin
         window_open_ff <= window_open_in;
      end
   end

   `PCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_first_mark) && $stable(rsp_last_mark), "stalled result transaction changed")
   `PCW_ASSERT_NOW(a_first_opens, rsp_valid && !window_open_ff, rsp_first_mark, "window result without first mark")
   `PCW_ASSERT_NOW(a_no_nested_first, rsp_valid && window_open_ff, !rsp_first_mark, "first mark inside an open window")
   `PCW_ASSERT_NOW(a_ready_on_stall, !req_ready, rsp_valid && !rsp_ready, "input stalled while output free")

endmodule

bind pretrigger_capture_window_core pcw_checker u_pcw_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pretrigger capture window core.
module tb;
   import pcw_pkg::*;

   localparam int RING_DEPTH    = 16384;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_COUNT   = 9;
   localparam int PHASE_ITEMS   = 216;
   localparam int PRINT_CAP     = 40;
   localparam longint TIMEOUT_NS = 64'd5_000_000;

   // Register indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       first_mark;
      logic                       last_mark;
   } window_beat_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0]   wdata;
      logic [SAMPLE_W-1:0]     pcm;
      logic                    trig;
      logic                    typed;
      logic                    beat_due;
      window_beat_type         beat;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       req_trigger = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_first_mark;
   logic                       rsp_last_mark;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Window predictor state
   logic [SAMPLE_W-1:0] hist_ring [RING_DEPTH];
   int unsigned wr_ptr, rd_ptr, fill_cnt, left_cnt, len_cfg, post_cfg;
   bit          in_event;

   window_beat_type pending_beats[$];

   int unsigned gap_pct, stall_pct, ready_calm, sender_calm;
   int unsigned error_count, samples_sent, triggers_sent, beats_checked;
   int unsigned windows_seen, csr_writes;

   pretrigger_capture_window_core #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_trigger    (req_trigger),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_first_mark (rsp_first_mark),
      .rsp_last_mark  (rsp_last_mark),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d window beats still expected", pending_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("[%0t] ERROR: %s", $time, what);
   endtask

   // Hold a written length inside 1..RING_DEPTH
   function automatic int unsigned clamp_len(input logic [PREROLL_W-1:0] v);
      if (v == 0) return 1;
      if (v > RING_DEPTH) return RING_DEPTH;
      return 32'(v);
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PREROLL: begin
            // A new length drops all history and any open window
            len_cfg  = clamp_len(data[PREROLL_W-1:0]);
            wr_ptr   = 0;
            rd_ptr   = 0;
            fill_cnt = 0;
            left_cnt = 0;
            in_event = 1'b0;
         end
         CSR_POSTROLL: post_cfg = 32'(data[POSTROLL_W-1:0]);
         default: ;
      endcase
   endfunction

   // Advance the ring by one sample and work out the window beat it releases
   function automatic bit predict_beat(input logic [SAMPLE_W-1:0] pcm, input logic trig,
                                       output window_beat_type beat);
      beat = '0;
      hist_ring[wr_ptr] = pcm;
      wr_ptr = (wr_ptr + 1 >= len_cfg) ? 0 : wr_ptr + 1;
      if (fill_cnt < len_cfg) fill_cnt++;
      if (!in_event) begin
         if (!trig) return 1'b0;
         in_event        = 1'b1;
         rd_ptr          = (wr_ptr + len_cfg - fill_cnt) % len_cfg;
         left_cnt        = fill_cnt + post_cfg;
         beat.first_mark = 1'b1;
      end
      beat.pcm = hist_ring[rd_ptr];
      rd_ptr = (rd_ptr + 1 >= len_cfg) ? 0 : rd_ptr + 1;
      if (left_cnt > 0) left_cnt--;
      beat.last_mark = (left_cnt == 0);
      if (beat.last_mark) in_event = 1'b0;
      return 1'b1;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.kind      = ROW_CSR;
      r.reg_index = idx;
      r.wdata     = data;
      return r;
   endfunction

   function automatic plan_row_type sample_row(input logic [SAMPLE_W-1:0] pcm,
                                               input logic trig);
      plan_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.pcm  = pcm;
      r.trig = trig;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input logic [SAMPLE_W-1:0] pcm,
                                              input logic trig,
                                              input logic due,
                                              input logic [SAMPLE_W-1:0] out,
                                              input logic first_mark, input logic last_mark);
      plan_row_type r;
      r = sample_row(pcm, trig);
      r.typed           = 1'b1;
      r.beat_due        = due;
      r.beat.pcm        = out;
      r.beat.first_mark = first_mark;
      r.beat.last_mark  = last_mark;
      return r;
   endfunction

   // Write one register; the caller lowers the write enable afterwards
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(idx, data);
      csr_writes++;
   endtask

   // Offer one sample, hold it until accepted, then record its expected beat
   task automatic push_sample(input logic [SAMPLE_W-1:0] pcm, input logic trig,
                              input logic typed, input logic typed_due,
                              input window_beat_type typed_beat);
      window_beat_type beat;
      bit              due;
      csr_wr_en     <= 1'b0;
      req_valid     <= 1'b1;
      req_sample_in <= pcm;
      req_trigger   <= trig;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      due = predict_beat(pcm, trig, beat);
      if (typed) begin
         due  = typed_due;
         beat = typed_beat;
      end
      if (due) pending_beats.push_back(beat);
      samples_sent++;
      if (trig) triggers_sent++;
   endtask

   // Drop valid, wait for every expected beat, then let the pipeline empty
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Idle the sender now and then, with calm stretches in between
   task automatic maybe_pause();
      if (sender_calm > 0) begin
         sender_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
         sender_calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_pcm();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Receiver: stall at random, with calm stretches
   always @(posedge clock) begin
      if (ready_calm > 0) begin
         ready_calm--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
         ready_calm = $urandom_range(20, 60);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      window_beat_type want;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            flag_mismatch("rsp_valid is unknown");
         end else if (rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat pcm=%0d first=%b last=%b",
                                       rsp_sample_out, rsp_first_mark, rsp_last_mark));
            end else begin
               want = pending_beats.pop_front();
               if (rsp_sample_out !== want.pcm)
                  flag_mismatch($sformatf("pcm %0d, expected %0d", rsp_sample_out, want.pcm));
               if (rsp_first_mark !== want.first_mark)
                  flag_mismatch($sformatf("first_mark %b, expected %b",
                                          rsp_first_mark, want.first_mark));
               if (rsp_last_mark !== want.last_mark)
                  flag_mismatch($sformatf("last_mark %b, expected %b",
                                          rsp_last_mark, want.last_mark));
               beats_checked++;
               if (want.first_mark) windows_seen++;
            end
         end
      end
   end

   initial begin
      plan_row_type    plan[$];
      window_beat_type no_beat;
      int unsigned     phase, n, trig_pct;
      logic [CSR_DATA_W-1:0] len_word, post_word;
      bit              write_len, prev_item;

      no_beat   = '0;
      gap_pct   = 0;
      stall_pct = 0;
      len_cfg   = clamp_len(PREROLL_W'(PREROLL_RESET));
      post_cfg  = POSTROLL_RESET;
      wr_ptr    = 0;
      rd_ptr    = 0;
      fill_cnt  = 0;
      left_cnt  = 0;
      in_event  = 1'b0;

      // Reset values: trigger on the second sample replays the first
      plan.push_back(typed_row(16'h0101, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(typed_row(16'h8000, 1'b1, 1'b1, 16'h0101, 1'b1, 1'b0));
      plan.push_back(sample_row(16'h7FFF, 1'b0));
      // Short ring with a short tail; rewriting the length ends the open window
      plan.push_back(csr_row(CSR_POSTROLL, 24'd2));
      plan.push_back(csr_row(CSR_PREROLL, 24'd3));
      plan.push_back(typed_row(16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(typed_row(16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(typed_row(16'h0001, 1'b1, 1'b1, 16'h7FFF, 1'b1, 1'b0));
      plan.push_back(sample_row(16'h1234, 1'b1));      // trigger during event
      plan.push_back(sample_row(16'hFFFF, 1'b0));
      plan.push_back(sample_row(16'h0005, 1'b0));
      plan.push_back(sample_row(16'h0006, 1'b1));      // trigger on the final beat
      plan.push_back(typed_row(16'h0007, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(sample_row(16'h0008, 1'b1));      // history kept across windows
      plan.push_back(sample_row(16'h0009, 1'b0));
      // Zero length becomes one; spare indexes must change nothing
      plan.push_back(csr_row(CSR_PREROLL, 24'd0));
      plan.push_back(csr_row(CSR_POSTROLL, 24'd0));
      plan.push_back(csr_row(CSR_SPARE_LO, 24'd5));
      plan.push_back(csr_row(CSR_SPARE_HI, 24'd7));
      plan.push_back(typed_row(16'h000A, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(typed_row(16'h4000, 1'b1, 1'b1, 16'h4000, 1'b1, 1'b1));
      // Tail rewritten mid-window applies only at the next trigger
      plan.push_back(csr_row(CSR_POSTROLL, 24'd3));
      plan.push_back(sample_row(16'h00AA, 1'b1));
      plan.push_back(csr_row(CSR_POSTROLL, 24'd0));
      plan.push_back(sample_row(16'h00BB, 1'b0));
      plan.push_back(sample_row(16'h00CC, 1'b0));
      plan.push_back(sample_row(16'h00DD, 1'b0));
      plan.push_back(typed_row(16'h00EE, 1'b1, 1'b1, 16'h00EE, 1'b1, 1'b1));
      // Upper data bits above the length field are dropped
      plan.push_back(csr_row(CSR_PREROLL, 24'hFF8002));
      plan.push_back(typed_row(16'h1111, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(typed_row(16'h2222, 1'b1, 1'b1, 16'h1111, 1'b1, 1'b0));
      plan.push_back(typed_row(16'h3333, 1'b0, 1'b1, 16'h2222, 1'b0, 1'b1));
      // Oversized length clamps to the full ring; longest tail
      plan.push_back(csr_row(CSR_PREROLL, 24'h007FFF));
      plan.push_back(csr_row(CSR_POSTROLL, 24'hFFFFFF));
      plan.push_back(typed_row(16'h5555, 1'b1, 1'b1, 16'h5555, 1'b1, 1'b0));
      plan.push_back(typed_row(16'hAAAA, 1'b0, 1'b1, 16'hAAAA, 1'b0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      prev_item = 1'b1;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (prev_item) drain_and_settle();
            csr_write(plan[i].reg_index, plan[i].wdata);
            prev_item = 1'b0;
         end else begin
            push_sample(plan[i].pcm, plan[i].trig, plan[i].typed, plan[i].beat_due,
                        plan[i].beat);
            prev_item = 1'b1;
         end
      end

      // Random phases, each with its own tail and trigger rate; all but one write a new ring length
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_and_settle();
         write_len = 1'b1;
         len_word  = CSR_DATA_W'($urandom);
         case (phase)
            0: begin len_word = 24'd0;     post_word = 24'd0;  trig_pct = 30; end
            1: begin len_word = 24'd4;     post_word = 24'd5;  trig_pct = 15; end
            2: begin
               len_word  = CSR_DATA_W'($urandom_range(2, 32));
               post_word = CSR_DATA_W'($urandom_range(0, 40));
               trig_pct  = 10;
            end
            3: begin len_word = 24'd16384; post_word = 24'd20; trig_pct = 5; end
            4: begin write_len = 1'b0;     post_word = 24'd0;  trig_pct = 25; end
            5: begin
               len_word[PREROLL_W-1:0] = PREROLL_W'($urandom_range(1, 64));
               post_word = CSR_DATA_W'($urandom_range(0, 64));
               trig_pct  = 10;
            end
            6: begin len_word = 24'd3;     post_word = 24'hFFFFFF; trig_pct = 5; end
            7: begin
               len_word  = CSR_DATA_W'($urandom_range(1, 16));
               post_word = CSR_DATA_W'($urandom_range(0, 16));
               trig_pct  = 20;
            end
            default: begin
               len_word  = CSR_DATA_W'($urandom_range(1, 48));
               post_word = CSR_DATA_W'($urandom_range(0, 100));
               trig_pct  = 8;
            end
         endcase
         csr_write(CSR_POSTROLL, post_word);
         if (write_len) csr_write(CSR_PREROLL, len_word);

         case (phase / 3)
            0: begin gap_pct = 16; stall_pct = 68; end
            1: begin gap_pct = 68; stall_pct = 16; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 && phase % 3 == 1) drain_and_settle();
            maybe_pause();
            push_sample(pick_pcm(), $urandom_range(0, 99) < trig_pct, 1'b0, 1'b0, no_beat);
         end
      end

      drain_and_settle();
      $display("Sent %0d samples with %0d triggers over %0d register writes;",
               samples_sent, triggers_sent, csr_writes);
      $display("checked %0d window beats across %0d windows.", beats_checked, windows_seen);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", error_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/pcw_pkg.sv
sv/pcw_ring.sv
sv/pretrigger_capture_window_core.sv
sv/pcw_checker.sv
tb/tb.sv
